FILE: hdl/date_offset_with_weekday_top_assert.svh
// assertion shorthands used by the date offset core (dow_core)
// clk_i and rst_ni must be visible where these are used
`ifndef DATE_OFFSET_WITH_WEEKDAY_TOP_ASSERT_SVH
`define DATE_OFFSET_WITH_WEEKDAY_TOP_ASSERT_SVH

// same-cycle implication
`define DOW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DOW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dow_pkg.sv
package dow_pkg;

  // field widths
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 16;
  localparam int WdayW  = 3;

  // day count bits that take part, and the signed day accumulator width
  localparam int CountBits = 16;
  localparam int NBits     = (CountBits < CountW) ? CountBits : CountW;
  localparam int Dw        = ((NBits > DayW) ? NBits : DayW) + 2;

  localparam logic [YearW-1:0]  YearMin  = 14'd1;
  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayLong  = 5'd31;

  // year modulo 400 tracking
  localparam int              YmodW   = 9;
  localparam logic [YmodW-1:0] YmodTop = 9'd399;

  // reciprocal constants for the shared multiplier
  localparam int              MulAW     = 14;
  localparam int              MulBW     = 13;
  localparam int              QuotW     = 7;
  localparam logic [MulBW-1:0] Div100Mul = 13'd5243;
  localparam int              Div100Sh  = 19;
  localparam logic [MulBW-1:0] Div7Mul   = 13'd2341;
  localparam int              Div7Sh    = 14;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic              go_back;
    logic [CountW-1:0] day_count;
  } in_beat_t;

  typedef struct packed {
    logic [YearW-1:0]  new_year;
    logic [MonthW-1:0] new_month;
    logic [DayW-1:0]   new_day;
    logic [WdayW-1:0]  weekday;
    logic              out_of_range;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_ctl_t;

  // leap test on year mod 400
  function automatic logic leap_of(logic [YmodW-1:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [DayW-1:0] month_days(logic leap, logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MonthFeb:                len = leap ? 5'd29 : 5'd28;
      default:                 len = DayLong;
    endcase
    return len;
  endfunction

  // floor(13 * (m + 1) / 5) for the shifted month 3..14
  function automatic logic [5:0] zeller_month(logic [MonthW-1:0] zm);
    logic [5:0] t;
    unique case (zm)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/dow_core.sv
`include "date_offset_with_weekday_top_assert.svh"

module dow_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dow_pkg::in_beat_t in_i,
  input  logic              hold_i,
  output dow_pkg::core_ctl_t ctl_o,
  output dow_pkg::out_beat_t res_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_YMOD  = 10'b0000000100,
    S_CLAMP = 10'b0000001000,
    S_STEP  = 10'b0000010000,
    S_ZDIV  = 10'b0000100000,
    S_ZSUM  = 10'b0001000000,
    S_ZMOD  = 10'b0010000000,
    S_ZREM  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  localparam int Dw = dow_pkg::Dw;
  localparam logic signed [Dw-1:0] DOne  = Dw'(1);
  localparam logic signed [Dw-1:0] DLong = Dw'(31);

  state_e state_q, state_d;

  logic [dow_pkg::YearW-1:0]  y_q, y_d;
  logic [dow_pkg::MonthW-1:0] m_q, m_d;
  logic signed [Dw-1:0]       d_q, d_d;
  logic [dow_pkg::NBits-1:0]  n_q, n_d;
  logic                       back_q, back_d;
  logic                       flag_q, flag_d;
  logic [dow_pkg::YmodW-1:0]  ymod_q, ymod_d;
  logic [dow_pkg::QuotW-1:0]  q_q, q_d;
  logic [9:0]                 h_q, h_d;
  logic [dow_pkg::WdayW-1:0]  wd_q, wd_d;

  // shared reciprocal multiplier
  logic [dow_pkg::MulAW-1:0] mul_a;
  logic [dow_pkg::MulBW-1:0] mul_b;
  logic [26:0]               prod;

  // zeller shifted year and month
  logic [dow_pkg::YearW-1:0]  zy;
  logic [dow_pkg::MonthW-1:0] zm;

  // month length lookup
  logic [dow_pkg::MonthW-1:0] lk_m;
  logic [dow_pkg::DayW-1:0]   dim;
  logic signed [Dw-1:0]       dim_s;

  // remainder by 100 and helper products
  logic [dow_pkg::YearW-1:0] rem_src;
  logic [dow_pkg::YearW-1:0] rem_full;
  logic [6:0]                rem;
  logic [11:0]               t21;
  logic [8:0]                t5;
  logic [9:0]                r7;

  // clamp and step arithmetic
  logic [dow_pkg::DayW-1:0] d0;
  logic signed [Dw-1:0]     d0_s;
  logic signed [Dw-1:0]     n_s;
  logic signed [Dw-1:0]     addend;
  logic signed [Dw-1:0]     d_sum;

  logic [dow_pkg::YearW-1:0]  y_in;
  logic [dow_pkg::MonthW-1:0] m_in;

  assign zy = (m_q <= dow_pkg::MonthFeb) ? y_q - 14'd1 : y_q;
  assign zm = (m_q <= dow_pkg::MonthFeb) ? m_q + 4'd12 : m_q;

  always_comb begin
    if (state_q == S_ZMOD) begin
      mul_a = dow_pkg::MulAW'(h_q);
      mul_b = dow_pkg::Div7Mul;
    end else begin
      mul_a = (state_q == S_DIV) ? y_q : zy;
      mul_b = dow_pkg::Div100Mul;
    end
  end
  assign prod = 27'(mul_a) * 27'(mul_b);

  assign lk_m  = ((state_q == S_STEP) && back_q) ? m_q - 4'd1 : m_q;
  assign dim   = dow_pkg::month_days(dow_pkg::leap_of(ymod_q), lk_m);
  assign dim_s = signed'({{(Dw - dow_pkg::DayW){1'b0}}, dim});

  assign rem_src  = (state_q == S_YMOD) ? y_q : zy;
  assign rem_full = rem_src - 14'(q_q) * 14'd100;
  assign rem      = rem_full[6:0];
  assign t21      = 12'(q_q) * 12'd21;
  assign t5       = 9'(rem) * 9'd5;
  assign r7       = h_q - 10'(q_q) * 10'd7;

  // day clamp into the starting month
  always_comb begin
    if (d_q[dow_pkg::DayW-1:0] == '0) begin
      d0 = 5'd1;
    end else if (d_q[dow_pkg::DayW-1:0] > dim) begin
      d0 = dim;
    end else begin
      d0 = d_q[dow_pkg::DayW-1:0];
    end
  end
  assign d0_s = signed'({{(Dw - dow_pkg::DayW){1'b0}}, d0});
  assign n_s  = signed'({{(Dw - dow_pkg::NBits){1'b0}}, n_q});

  // one adder walks the months
  always_comb begin
    if (!back_q) begin
      addend = -dim_s;
    end else if (m_q == dow_pkg::MonthJan) begin
      addend = DLong;
    end else begin
      addend = dim_s;
    end
  end
  assign d_sum = d_q + addend;

  assign y_in = in_i.start_year;
  assign m_in = in_i.start_month;

  always_comb begin
    state_d = state_q;
    y_d     = y_q;
    m_d     = m_q;
    d_d     = d_q;
    n_d     = n_q;
    back_d  = back_q;
    flag_d  = flag_q;
    ymod_d  = ymod_q;
    q_d     = q_q;
    h_d     = h_q;
    wd_d    = wd_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          flag_d = 1'b0;
          if (y_in < dow_pkg::YearMin) begin
            y_d    = dow_pkg::YearMin;
            flag_d = 1'b1;
          end else if (y_in > dow_pkg::YearMax) begin
            y_d    = dow_pkg::YearMax;
            flag_d = 1'b1;
          end else begin
            y_d = y_in;
          end
          if (m_in < dow_pkg::MonthJan) begin
            m_d = dow_pkg::MonthJan;
          end else if (m_in > dow_pkg::MonthDec) begin
            m_d = dow_pkg::MonthDec;
          end else begin
            m_d = m_in;
          end
          d_d     = signed'({{(Dw - dow_pkg::DayW){1'b0}}, in_i.start_day});
          n_d     = in_i.day_count[dow_pkg::NBits-1:0];
          back_d  = in_i.go_back;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        q_d     = prod[dow_pkg::Div100Sh +: dow_pkg::QuotW];
        state_d = S_YMOD;
      end
      S_YMOD: begin
        ymod_d  = 9'(q_q[1:0]) * 9'd100 + 9'(rem);
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        d_d     = back_q ? d0_s - n_s : d0_s + n_s;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (!back_q) begin
          if (d_q > dim_s) begin
            if (m_q == dow_pkg::MonthDec) begin
              if (y_q == dow_pkg::YearMax) begin
                // ran past the last year
                m_d     = dow_pkg::MonthDec;
                d_d     = DLong;
                flag_d  = 1'b1;
                state_d = S_ZDIV;
              end else begin
                y_d    = y_q + 14'd1;
                ymod_d = (ymod_q == dow_pkg::YmodTop) ? '0 : ymod_q + 9'd1;
                m_d    = dow_pkg::MonthJan;
                d_d    = d_sum;
              end
            end else begin
              m_d = m_q + 4'd1;
              d_d = d_sum;
            end
          end else begin
            state_d = S_ZDIV;
          end
        end else begin
          if (d_q < DOne) begin
            if (m_q != dow_pkg::MonthJan) begin
              m_d = m_q - 4'd1;
              d_d = d_sum;
            end else if (y_q == dow_pkg::YearMin) begin
              // ran before the first year
              d_d     = DOne;
              flag_d  = 1'b1;
              state_d = S_ZDIV;
            end else begin
              y_d    = y_q - 14'd1;
              ymod_d = (ymod_q == '0) ? dow_pkg::YmodTop : ymod_q - 9'd1;
              m_d    = dow_pkg::MonthDec;
              d_d    = d_sum;
            end
          end else begin
            state_d = S_ZDIV;
          end
        end
      end
      S_ZDIV: begin
        q_d     = prod[dow_pkg::Div100Sh +: dow_pkg::QuotW];
        state_d = S_ZSUM;
      end
      S_ZSUM: begin
        h_d = 10'(t21[11:2]) + 10'(t5[8:2]) + 10'(dow_pkg::zeller_month(zm))
            + 10'(d_q[dow_pkg::DayW-1:0]) - 10'd1;
        state_d = S_ZMOD;
      end
      S_ZMOD: begin
        q_d     = prod[dow_pkg::Div7Sh +: dow_pkg::QuotW];
        state_d = S_ZREM;
      end
      S_ZREM: begin
        wd_d    = r7[dow_pkg::WdayW-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!hold_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    m_q    <= m_d;
    d_q    <= d_d;
    n_q    <= n_d;
    back_q <= back_d;
    flag_q <= flag_d;
    ymod_q <= ymod_d;
    q_q    <= q_d;
    h_q    <= h_d;
    wd_q   <= wd_d;
  end

  assign ctl_o.busy = (state_q != S_IDLE);
  assign ctl_o.done = (state_q == S_OUT) && !hold_i;

  assign res_o.new_year     = y_q;
  assign res_o.new_month    = m_q;
  assign res_o.new_day      = d_q[dow_pkg::DayW-1:0];
  assign res_o.weekday      = wd_q;
  assign res_o.out_of_range = flag_q;

  `DOW_ASSERT_IMP(a_start_idle, start_i, state_q == S_IDLE, "start while busy")
  `DOW_ASSERT_IMP(a_year_range, state_q != S_IDLE,
                  (y_q >= dow_pkg::YearMin) && (y_q <= dow_pkg::YearMax), "year out of range")
  `DOW_ASSERT_IMP(a_step_regs, state_q == S_STEP,
                  (ymod_q <= dow_pkg::YmodTop) && (m_q >= dow_pkg::MonthJan) &&
                  (m_q <= dow_pkg::MonthDec), "bad month or year phase while stepping")
  `DOW_ASSERT_IMP(a_wday, ctl_o.done, res_o.weekday <= 3'd6, "weekday above saturday")
  `DOW_ASSERT_NXT(a_out_idle, (state_q == S_OUT) && !hold_i, state_q == S_IDLE,
                  "no return to idle after handoff")

endmodule

FILE: hdl/date_offset_with_weekday_top.sv
// channel | direction | handshake               | payload
// in      | input     | in_valid_i/in_stall_o   | in_data_i  (dow_pkg::in_beat_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o (dow_pkg::out_beat_t)
//
// after the accepting edge the core runs S_DIV, S_YMOD, S_CLAMP, S_STEP per
// month walked, S_ZDIV, S_ZSUM, S_ZMOD, S_ZREM and S_OUT before out_valid_o,
// then S_IDLE; the walk adds or removes one month length per cycle
// in_stall_o is high from the accepting edge until the result moves to the
// output register; a result waiting there does not block the next beat
// rst_ni clears the sequencer and the output valid, nothing else
module date_offset_with_weekday_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dow_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dow_pkg::out_beat_t out_data_o
);

  dow_pkg::core_ctl_t ctl;
  dow_pkg::out_beat_t res;
  logic               start;
  logic               hold;

  logic               out_valid_q, out_valid_d;
  dow_pkg::out_beat_t out_data_q, out_data_d;

  // input taken only while the sequencer is idle
  assign in_stall_o = ctl.busy;
  assign start      = in_valid_i && !ctl.busy;

  // the core waits in S_OUT while a result sits unclaimed in the output register
  assign hold = out_valid_q && out_stall_i;

  dow_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .in_i    (in_data_i),
    .hold_i  (hold),
    .ctl_o   (ctl),
    .res_o   (res)
  );

  // output register, loaded when the core hands off
  always_comb begin
    out_valid_d = ctl.done || hold;
    out_data_d  = ctl.done ? res : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: test/date_offset_with_weekday_top_tb.sv
`timescale 1ns / 100ps

class date_scoreboard;
  dow_pkg::out_beat_t expected_dates_q[$];
  int unsigned        mismatches;

  function new();
    mismatches = 0;
  endfunction

  function bit leap_year(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function int month_length(int y, int m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // zeller, 0 is sunday
  function int zeller_weekday(int y, int m, int d);
    int k;
    int j;
    int h;
    if (m <= 2) begin
      m += 12;
      y -= 1;
    end
    k = y % 100;
    j = y / 100;
    h = 21 * j / 4 + 5 * k / 4 + 13 * (m + 1) / 5 + d - 1;
    return h % 7;
  endfunction

  function dow_pkg::out_beat_t offset_date(dow_pkg::in_beat_t b);
    int                 y;
    int                 m;
    int                 d;
    int                 n;
    bit                 clamped;
    dow_pkg::out_beat_t r;
    y       = int'(b.start_year);
    m       = int'(b.start_month);
    d       = int'(b.start_day);
    n       = int'(b.day_count) & ((1 << dow_pkg::NBits) - 1);
    clamped = 1'b0;
    if (y < int'(dow_pkg::YearMin)) begin
      y       = int'(dow_pkg::YearMin);
      clamped = 1'b1;
    end
    if (y > int'(dow_pkg::YearMax)) begin
      y       = int'(dow_pkg::YearMax);
      clamped = 1'b1;
    end
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_length(y, m)) d = month_length(y, m);
    if (!b.go_back) begin
      d += n;
      while (d > month_length(y, m)) begin
        d -= month_length(y, m);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
          if (y > int'(dow_pkg::YearMax)) begin
            y       = int'(dow_pkg::YearMax);
            m       = 12;
            d       = 31;
            clamped = 1'b1;
            break;
          end
        end
      end
    end else begin
      d -= n;
      while (d < 1) begin
        if (m != 1) begin
          m--;
          d += month_length(y, m);
        end else begin
          y--;
          if (y < int'(dow_pkg::YearMin)) begin
            y       = int'(dow_pkg::YearMin);
            m       = 1;
            d       = 1;
            clamped = 1'b1;
            break;
          end
          m = 12;
          d += 31;
        end
      end
    end
    r.new_year     = dow_pkg::YearW'(y);
    r.new_month    = dow_pkg::MonthW'(m);
    r.new_day      = dow_pkg::DayW'(d);
    r.weekday      = dow_pkg::WdayW'(zeller_weekday(y, m, d));
    r.out_of_range = clamped;
    return r;
  endfunction

  function void note_start(dow_pkg::in_beat_t b);
    expected_dates_q.push_back(offset_date(b));
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(dow_pkg::out_beat_t got);
    dow_pkg::out_beat_t want;
    if (expected_dates_q.size() == 0) begin
      $error("result beat with no date pending: %p", got);
      mismatches++;
      return;
    end
    want = expected_dates_q.pop_front();
    check_field("new_year", want.new_year, got.new_year);
    check_field("new_month", want.new_month, got.new_month);
    check_field("new_day", want.new_day, got.new_day);
    check_field("weekday", want.weekday, got.weekday);
    check_field("out_of_range", want.out_of_range, got.out_of_range);
  endfunction
endclass

module date_offset_with_weekday_top_tb;

  localparam int ClkPeriod      = 4;
  localparam int ResetCycles    = 7;
  // random beats per idle phase, three phases
  localparam int RandomPerPhase = 82;
  // covers a full 16-bit walk with stalls on top of it
  localparam int QuietLimit     = 40000;
  // after the last result, long enough for one more full walk to show up
  localparam int DrainCycles    = 2500;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  dow_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dow_pkg::out_beat_t out_data_o;

  date_scoreboard sb;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    quiet_cycles   = 0;

  date_offset_with_weekday_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // receiver backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: results are checked before the input of the same edge is noted,
  // the block's latency keeps the two from belonging together anyway
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_start(in_data_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      // watchdog: nothing moved for too long
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one beat into the block, with random gaps ahead of it
  // valid gets one assignment per falling edge, so back-to-back beats keep it high
  task automatic send_beat(dow_pkg::in_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    // payload held until the edge that takes it
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic dow_pkg::in_beat_t date_beat(int y, int m, int d, bit back, int n);
    dow_pkg::in_beat_t b;
    b.start_year  = dow_pkg::YearW'(y);
    b.start_month = dow_pkg::MonthW'(m);
    b.start_day   = dow_pkg::DayW'(d);
    b.go_back     = back;
    b.day_count   = dow_pkg::CountW'(n);
    return b;
  endfunction

  // mostly sane dates, weighted toward the year limits and small counts
  // so that both clamps and long walks come up often
  function automatic dow_pkg::in_beat_t random_beat();
    int unsigned y;
    int unsigned m;
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) y = $urandom_range(16383);
    else if (pick < 22) y = $urandom_range(9999, 9985);
    else if (pick < 36) y = $urandom_range(15, 1);
    else y = $urandom_range(9999, 1);
    m = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
    pick = $urandom_range(99);
    if (pick < 12) n = $urandom_range(65535);
    else if (pick < 40) n = $urandom_range(3000);
    else n = $urandom_range(400);
    return date_beat(y, m, $urandom_range(31), 1'($urandom_range(1)), n);
  endfunction

  initial begin
    sb             = new();
    send_idle_pct  = 28;
    recv_stall_pct = 67;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // leap rules: divisible by 400, century, plain
    send_beat(date_beat(2000, 2, 28, 1'b0, 1));
    send_beat(date_beat(1900, 2, 28, 1'b0, 1));
    send_beat(date_beat(2024, 3, 1, 1'b1, 1));
    // year boundaries in both directions
    send_beat(date_beat(2023, 12, 31, 1'b0, 1));
    send_beat(date_beat(2024, 1, 1, 1'b1, 1));
    // start year zero and above range
    send_beat(date_beat(0, 6, 15, 1'b0, 10));
    send_beat(date_beat(16383, 6, 15, 1'b1, 10));
    // month zero and above twelve
    send_beat(date_beat(2021, 0, 10, 1'b0, 5));
    send_beat(date_beat(2021, 15, 10, 1'b1, 5));
    // day zero and day past the month end
    send_beat(date_beat(2021, 5, 0, 1'b0, 3));
    send_beat(date_beat(2023, 2, 31, 1'b0, 0));
    send_beat(date_beat(2024, 2, 31, 1'b1, 0));
    send_beat(date_beat(2022, 4, 31, 1'b0, 1));
    // zero count both ways
    send_beat(date_beat(1, 1, 1, 1'b0, 0));
    send_beat(date_beat(9999, 12, 31, 1'b1, 0));
    // overflow past the last year, underflow before the first
    send_beat(date_beat(9999, 12, 31, 1'b0, 1));
    send_beat(date_beat(1, 1, 1, 1'b1, 1));
    send_beat(date_beat(9900, 3, 3, 1'b0, 65535));
    send_beat(date_beat(100, 8, 8, 1'b1, 65535));
    // longest walks that stay in range
    send_beat(date_beat(1, 1, 1, 1'b0, 65535));
    send_beat(date_beat(9999, 12, 31, 1'b1, 65535));
    // every input bit high, then a mid-range year
    send_beat(date_beat(16383, 15, 31, 1'b1, 65535));
    send_beat(date_beat(8191, 7, 16, 1'b0, 21845));
    send_beat(date_beat(1600, 2, 29, 1'b1, 366));

    // random part, three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 28;
          recv_stall_pct = 67;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 28;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RandomPerPhase) send_beat(random_beat());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then watch a while for anything extra
    while (sb.expected_dates_q.size() != 0) @(posedge clk_i);
    recv_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_dates_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
